>>> design/urb_pkg.sv
// shared constants and types for the uart transmit/receive ring buffers
// no dependencies; used by the core, the checker and the bench

package urb_pkg;

	// ring depths, powers of two, one slot kept empty
	localparam int unsigned TX_DEPTH = 16;
	localparam int unsigned RX_DEPTH = 16;
	localparam int unsigned TX_AW    = $clog2(TX_DEPTH);
	localparam int unsigned RX_AW    = $clog2(RX_DEPTH);

	// operation codes
	localparam logic [1:0] FUNC_APP_WRITE = 2'd0;
	localparam logic [1:0] FUNC_APP_READ  = 2'd1;
	localparam logic [1:0] FUNC_LINE_RX   = 2'd2;
	localparam logic [1:0] FUNC_TX_READY  = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TX_FULL  = 3'd1;
	localparam logic [2:0] ST_RX_EMPTY = 3'd2;
	localparam logic [2:0] ST_RX_DROP  = 3'd3;
	localparam logic [2:0] ST_TX_NONE  = 3'd4;

	typedef logic [TX_AW-1:0] tx_ptr_t;
	typedef logic [RX_AW-1:0] rx_ptr_t;

	// control flags held with a result item
	typedef struct packed {
		logic [2:0] status;
		logic       rx_pop;
		logic       tx_pop;
		logic       irq_en;
	} res_ctl_t;

endpackage

>>> design/urb_if.sv
// valid/ready channel interfaces for items in and result items out
// depends on nothing but plain logic types

interface urb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic [3:0] line_errors;
	logic       tx_ready;

	modport source (output valid, func, data_byte, line_errors, tx_ready, input ready);
	modport sink   (input valid, func, data_byte, line_errors, tx_ready, output ready);
endinterface

interface urb_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] read_byte;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       tx_irq_enable;

	modport source (output valid, status, read_byte, send_valid, send_byte, tx_irq_enable,
		input ready);
	modport sink   (input valid, status, read_byte, send_valid, send_byte, tx_irq_enable,
		output ready);
endinterface

>>> design/uart_tx_rx_ring_buffers_core.sv
// uart transmit/receive ring buffers: two byte rings in synchronous memories
// depends on urb_pkg and the channel interfaces in urb_if.sv
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   func, data_byte, line_errors, tx_ready
//  out_ch    out  valid/ready   status, read_byte, send_valid, send_byte, tx_irq_enable
//
// one item per cycle while results drain; each item gives one result in the cycle after it is taken
// pointers and the enable flag live in flops; the byte read comes from the memory's
// registered read port, which doubles as the result register for that byte
// a stalled result blocks the next item until it is taken (single result slot)
// reset clears pointers, enable and the result slot; memory contents stay undefined

module uart_tx_rx_ring_buffers_core (
	input  logic       clk,
	input  logic       arst_n,
	urb_in_if.sink     in_ch,
	urb_out_if.source  out_ch
);

	logic [7:0] tx_mem [urb_pkg::TX_DEPTH];
	logic [7:0] rx_mem [urb_pkg::RX_DEPTH];

	urb_pkg::tx_ptr_t tx_wr_q, tx_rd_q, tx_wr_nxt, tx_rd_nxt;
	urb_pkg::rx_ptr_t rx_wr_q, rx_rd_q, rx_wr_nxt, rx_rd_nxt;
	logic             irq_q;
	logic             out_valid_q;
	urb_pkg::res_ctl_t ctl_q, ctl_d;
	logic [7:0]       tx_rdata_q, rx_rdata_q;

	logic accept;
	logic tx_empty, tx_full, rx_empty, rx_full;
	logic tx_we, rx_we, tx_re, rx_re;
	logic irq_d;

	// pointer advance with wrap at the depth
	assign tx_wr_nxt = (tx_wr_q == urb_pkg::tx_ptr_t'(urb_pkg::TX_DEPTH - 1)) ? '0
		: tx_wr_q + urb_pkg::tx_ptr_t'(1);
	assign tx_rd_nxt = (tx_rd_q == urb_pkg::tx_ptr_t'(urb_pkg::TX_DEPTH - 1)) ? '0
		: tx_rd_q + urb_pkg::tx_ptr_t'(1);
	assign rx_wr_nxt = (rx_wr_q == urb_pkg::rx_ptr_t'(urb_pkg::RX_DEPTH - 1)) ? '0
		: rx_wr_q + urb_pkg::rx_ptr_t'(1);
	assign rx_rd_nxt = (rx_rd_q == urb_pkg::rx_ptr_t'(urb_pkg::RX_DEPTH - 1)) ? '0
		: rx_rd_q + urb_pkg::rx_ptr_t'(1);

	assign tx_empty = (tx_wr_q == tx_rd_q);
	assign tx_full  = (tx_wr_nxt == tx_rd_q);
	assign rx_empty = (rx_wr_q == rx_rd_q);
	assign rx_full  = (rx_wr_nxt == rx_rd_q);

	// handshake: take an item when the result slot is free or being emptied
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// operation decode
	always_comb begin
		tx_we = 1'b0;
		rx_we = 1'b0;
		tx_re = 1'b0;
		rx_re = 1'b0;
		irq_d = irq_q;
		ctl_d = '{status: urb_pkg::ST_OK, rx_pop: 1'b0, tx_pop: 1'b0, irq_en: 1'b0};
		unique case (in_ch.func)
			urb_pkg::FUNC_APP_WRITE: begin
				if (tx_full) begin
					ctl_d.status = urb_pkg::ST_TX_FULL;
				end else begin
					tx_we = 1'b1;
					if (in_ch.tx_ready) irq_d = 1'b1;
				end
			end
			urb_pkg::FUNC_APP_READ: begin
				if (rx_empty) begin
					ctl_d.status = urb_pkg::ST_RX_EMPTY;
				end else begin
					rx_re        = 1'b1;
					ctl_d.rx_pop = 1'b1;
				end
			end
			urb_pkg::FUNC_LINE_RX: begin
				if (in_ch.line_errors != 4'd0 || rx_full) begin
					ctl_d.status = urb_pkg::ST_RX_DROP;
				end else begin
					rx_we = 1'b1;
				end
			end
			urb_pkg::FUNC_TX_READY: begin
				if (tx_empty) begin
					irq_d        = 1'b0;
					ctl_d.status = urb_pkg::ST_TX_NONE;
				end else begin
					tx_re        = 1'b1;
					ctl_d.tx_pop = 1'b1;
				end
			end
			default: ;
		endcase
		ctl_d.irq_en = irq_d;
	end

	// pointer, enable and result slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_q     <= '0;
			tx_rd_q     <= '0;
			rx_wr_q     <= '0;
			rx_rd_q     <= '0;
			irq_q       <= 1'b0;
			out_valid_q <= 1'b0;
			ctl_q       <= '0;
		end else begin
			if (accept) begin
				if (tx_we) tx_wr_q <= tx_wr_nxt;
				if (tx_re) tx_rd_q <= tx_rd_nxt;
				if (rx_we) rx_wr_q <= rx_wr_nxt;
				if (rx_re) rx_rd_q <= rx_rd_nxt;
				irq_q       <= irq_d;
				ctl_q       <= ctl_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transmit ring memory, registered read
	always_ff @(posedge clk) begin
		if (accept && tx_we) tx_mem[tx_wr_q] <= in_ch.data_byte;
		if (accept && tx_re) tx_rdata_q <= tx_mem[tx_rd_q];
	end

	// receive ring memory, registered read
	always_ff @(posedge clk) begin
		if (accept && rx_we) rx_mem[rx_wr_q] <= in_ch.data_byte;
		if (accept && rx_re) rx_rdata_q <= rx_mem[rx_rd_q];
	end

	// result item
	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = ctl_q.status;
	assign out_ch.read_byte     = ctl_q.rx_pop ? rx_rdata_q : 8'd0;
	assign out_ch.send_valid    = ctl_q.tx_pop;
	assign out_ch.send_byte     = ctl_q.tx_pop ? tx_rdata_q : 8'd0;
	assign out_ch.tx_irq_enable = ctl_q.irq_en;

endmodule

>>> design/urb_checker.sv
// port-level checks for the uart ring buffer core, attached by bind
// depends on urb_pkg and uart_tx_rx_ring_buffers_core

module urb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [7:0] read_byte,
	input logic       send_valid,
	input logic [7:0] send_byte
);

	// an accepted item always yields a result in the next cycle
	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// a stalled result stays up
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result dropped or changed");

	// failed operations carry no bytes
	a_fail_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != urb_pkg::ST_OK |->
			read_byte == 8'd0 && send_byte == 8'd0 && !send_valid)
		else $error("byte fields set on a failed operation");

	// status is one of the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= urb_pkg::ST_TX_NONE)
		else $error("undefined status code");

endmodule

bind uart_tx_rx_ring_buffers_core urb_checker u_urb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.status     (out_ch.status),
	.read_byte  (out_ch.read_byte),
	.send_valid (out_ch.send_valid),
	.send_byte  (out_ch.send_byte)
);

>>> tb/uart_tx_rx_ring_buffers_core_test.sv
// self-checking bench for uart_tx_rx_ring_buffers_core: directed, fill/drain and random items
// depends on urb_pkg, the channel interfaces in urb_if.sv and the core itself

module uart_tx_rx_ring_buffers_core_test;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_byte;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       irq_en;
	} ring_result_t;

	// traffic mix used by the random test
	typedef enum int {
		MIX_EVEN,
		MIX_TX_FILL,
		MIX_TX_DRAIN,
		MIX_RX_FILL,
		MIX_RX_DRAIN
	} traffic_mix_t;

	logic clk;
	logic arst_n;

	urb_in_if  in_ch();
	urb_out_if out_ch();

	uart_tx_rx_ring_buffers_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// mirror of the ring contents, pointers and enable
	logic [7:0]       tx_ring [urb_pkg::TX_DEPTH];
	logic [7:0]       rx_ring [urb_pkg::RX_DEPTH];
	urb_pkg::tx_ptr_t tx_wr, tx_rd;
	urb_pkg::rx_ptr_t rx_wr, rx_rd;
	logic             irq_en_mirror;

	ring_result_t pending_results [$];
	int unsigned  fail_count;
	int unsigned  src_idle_pct;
	int unsigned  sink_idle_pct;
	int unsigned  sink_stall;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// apply one item to the mirrored rings and return the result it gives
	function automatic ring_result_t ring_predict(input logic [1:0] func, input logic [7:0] data,
		input logic [3:0] errs, input logic rdy);
		ring_result_t     res;
		urb_pkg::tx_ptr_t tx_next;
		urb_pkg::rx_ptr_t rx_next;
		res = '0;
		tx_next = tx_wr + 1'b1;
		rx_next = rx_wr + 1'b1;
		case (func)
			urb_pkg::FUNC_APP_WRITE: begin
				if (tx_next == tx_rd) begin
					res.status = urb_pkg::ST_TX_FULL;
				end else begin
					tx_ring[tx_wr] = data;
					tx_wr = tx_next;
					if (rdy)
						irq_en_mirror = 1'b1;
				end
			end
			urb_pkg::FUNC_APP_READ: begin
				if (rx_wr == rx_rd) begin
					res.status = urb_pkg::ST_RX_EMPTY;
				end else begin
					res.read_byte = rx_ring[rx_rd];
					rx_rd = rx_rd + 1'b1;
				end
			end
			urb_pkg::FUNC_LINE_RX: begin
				if (errs != 4'd0 || rx_next == rx_rd) begin
					res.status = urb_pkg::ST_RX_DROP;
				end else begin
					rx_ring[rx_wr] = data;
					rx_wr = rx_next;
				end
			end
			default: begin
				if (tx_wr == tx_rd) begin
					irq_en_mirror = 1'b0;
					res.status = urb_pkg::ST_TX_NONE;
				end else begin
					res.send_valid = 1'b1;
					res.send_byte = tx_ring[tx_rd];
					tx_rd = tx_rd + 1'b1;
				end
			end
		endcase
		res.irq_en = irq_en_mirror;
		return res;
	endfunction

	// predict on each accepted item, check each accepted result against the oldest prediction
	always @(posedge clk) begin
		ring_result_t want;
		ring_result_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				pending_results.push_back(ring_predict(in_ch.func, in_ch.data_byte,
					in_ch.line_errors, in_ch.tx_ready));
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.status, out_ch.read_byte, out_ch.send_valid, out_ch.send_byte,
					out_ch.tx_irq_enable};
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.read_byte !== want.read_byte ||
						got.send_valid !== want.send_valid ||
						got.send_byte !== want.send_byte || got.irq_en !== want.irq_en) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
		end
	end

	// result sink with random stall bursts
	always @(posedge clk) begin
		if (sink_idle_pct == 0) begin
			out_ch.ready <= 1'b1;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			out_ch.ready <= 1'b0;
			sink_stall <= $urandom_range(0, 6);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// offer one item, with an optional gap first, and hold it until accepted
	task automatic send_item(input logic [1:0] func, input logic [7:0] data,
		input logic [3:0] errs, input logic rdy);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.data_byte <= data;
		in_ch.line_errors <= errs;
		in_ch.tx_ready <= rdy;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// stop offering items until every predicted result has come back
	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		// let the last accepted item reach the queue first
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// empty-buffer cases, enable set/hold/clear, line error flags, byte extremes
	task automatic test_directed();
		src_idle_pct = 20;
		sink_idle_pct = 20;
		send_item(urb_pkg::FUNC_APP_READ, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_APP_WRITE, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_APP_WRITE, 8'hff, 4'h0, 1'b1);
		send_item(urb_pkg::FUNC_APP_WRITE, 8'ha5, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_TX_READY, 8'hff, 4'hf, 1'b1);
		send_item(urb_pkg::FUNC_LINE_RX, 8'hff, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_LINE_RX, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_LINE_RX, 8'h11, 4'h1, 1'b0);
		send_item(urb_pkg::FUNC_LINE_RX, 8'h22, 4'h2, 1'b0);
		send_item(urb_pkg::FUNC_LINE_RX, 8'h44, 4'h4, 1'b0);
		send_item(urb_pkg::FUNC_LINE_RX, 8'h88, 4'h8, 1'b0);
		send_item(urb_pkg::FUNC_LINE_RX, 8'hff, 4'hf, 1'b1);
		send_item(urb_pkg::FUNC_APP_READ, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_APP_READ, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_APP_READ, 8'h00, 4'h0, 1'b0);
		send_item(urb_pkg::FUNC_APP_WRITE, 8'h5a, 4'h0, 1'b1);
		send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
	endtask

	// fill each ring past full, then drain it past empty, so the pointers wrap
	task automatic test_fill_drain();
		src_idle_pct = 10;
		sink_idle_pct = 10;
		repeat (2) begin
			repeat (urb_pkg::TX_DEPTH + 1)
				send_item(urb_pkg::FUNC_APP_WRITE, 8'($urandom_range(0, 255)), 4'h0,
					1'($urandom));
			repeat (urb_pkg::TX_DEPTH + 1)
				send_item(urb_pkg::FUNC_TX_READY, 8'h00, 4'h0, 1'b0);
			repeat (urb_pkg::RX_DEPTH + 1)
				send_item(urb_pkg::FUNC_LINE_RX, 8'($urandom_range(0, 255)), 4'h0, 1'b0);
			repeat (urb_pkg::RX_DEPTH + 1)
				send_item(urb_pkg::FUNC_APP_READ, 8'h00, 4'h0, 1'b0);
		end
	endtask

	// pick an operation, leaning toward filling or draining one ring
	function automatic logic [1:0] pick_func(input traffic_mix_t mix);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_TX_FILL:  return r < 60 ? urb_pkg::FUNC_APP_WRITE :
				r < 75 ? urb_pkg::FUNC_TX_READY :
				r < 87 ? urb_pkg::FUNC_LINE_RX : urb_pkg::FUNC_APP_READ;
			MIX_TX_DRAIN: return r < 60 ? urb_pkg::FUNC_TX_READY :
				r < 75 ? urb_pkg::FUNC_APP_WRITE :
				r < 87 ? urb_pkg::FUNC_LINE_RX : urb_pkg::FUNC_APP_READ;
			MIX_RX_FILL:  return r < 60 ? urb_pkg::FUNC_LINE_RX :
				r < 75 ? urb_pkg::FUNC_APP_READ :
				r < 87 ? urb_pkg::FUNC_APP_WRITE : urb_pkg::FUNC_TX_READY;
			MIX_RX_DRAIN: return r < 60 ? urb_pkg::FUNC_APP_READ :
				r < 75 ? urb_pkg::FUNC_LINE_RX :
				r < 87 ? urb_pkg::FUNC_APP_WRITE : urb_pkg::FUNC_TX_READY;
			default:      return 2'($urandom_range(0, 3));
		endcase
	endfunction

	// random items in blocks, each block with its own mix and idling level
	task automatic test_random();
		traffic_mix_t mix;
		logic [3:0]   errs;
		int unsigned  idle_levels [4] = '{0, 10, 30, 60};
		repeat (40) begin
			mix = traffic_mix_t'($urandom_range(0, 4));
			src_idle_pct = idle_levels[$urandom_range(0, 3)];
			sink_idle_pct = idle_levels[$urandom_range(0, 3)];
			repeat (40) begin
				// mostly clean receive flags so the rx ring actually fills
				errs = ($urandom_range(0, 99) < 75) ? 4'h0 : 4'($urandom_range(1, 15));
				send_item(pick_func(mix), 8'($urandom_range(0, 255)), errs, 1'($urandom));
			end
		end
	endtask

	// last stretch at full rate with no idling on either side
	task automatic test_back_to_back();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		repeat (200)
			send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				($urandom_range(0, 1) != 0) ? 4'h0 : 4'($urandom_range(0, 15)), 1'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = urb_pkg::FUNC_APP_WRITE;
		in_ch.data_byte = 8'h00;
		in_ch.line_errors = 4'h0;
		in_ch.tx_ready = 1'b0;
		out_ch.ready = 1'b1;
		tx_wr = '0;
		tx_rd = '0;
		rx_wr = '0;
		rx_rd = '0;
		irq_en_mirror = 1'b0;
		fail_count = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		sink_stall = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_for_results();
		test_fill_drain();
		test_random();
		wait_for_results();
		test_back_to_back();

		// drain and let the result slot settle
		wait_for_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
design/urb_pkg.sv
design/urb_if.sv
design/uart_tx_rx_ring_buffers_core.sv
design/urb_checker.sv
tb/uart_tx_rx_ring_buffers_core_test.sv
